// ===== rtl/core/rfmq_pkg.sv =====
// Shared types and constants for the receiver-filtered mailbox queue.
// No dependencies.
package rfmq_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY   = 2'd0,
        CFG_SIZE_LIMIT = 2'd1,
        CFG_CLOSED     = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CLOSED     = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_NO_MATCH   = 3'd4,
        ST_BAD_BUFFER = 3'd5
    } status_t;

    typedef struct packed {
        logic load;
        logic finish;
    } rfmq_cmd_t;

endpackage

// ===== rtl/core/receiver_filtered_mailbox_queue_top.sv =====
// Top level of the receiver-filtered mailbox queue: config registers, controller, datapath.
// Depends on rfmq_pkg, rfmq_ctrl and rfmq_dp.
//
//  Channel   Handshake           Beat
//  request   start / busy        kind, sender, receiver, msg_kind, msg_size, payload, room
//  result    done (one cycle)    status, out_kind, out_sender, out_id, bytes_copied,
//                                out_payload, held
//  config    cfg_we              cfg_idx, cfg_data
//
// A request has a load cycle, which registers the match over all slots, and an execute
// cycle, which forms the pick, shift collapse and result. The result beat shows
// on done in the cycle after, overlapping the next request. Reset empties the queue and
// sets the id counter to one. The receiver cannot stall.
module receiver_filtered_mailbox_queue_top
    import rfmq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] sender,
    input  logic [31:0] receiver,
    input  logic [7:0]  msg_kind,
    input  logic [15:0] msg_size,
    input  logic [63:0] payload,
    input  logic [15:0] room,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  out_kind,
    output logic [31:0] out_sender,
    output logic [31:0] out_id,
    output logic [15:0] bytes_copied,
    output logic [63:0] out_payload,
    output logic [$clog2(DEPTH+1)-1:0] held
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [4:0]  capacity_reg;
    logic [15:0] size_limit_reg;
    logic        closed_reg;
    logic [CNT_W-1:0] cap_int;
    rfmq_cmd_t   cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= 5'd16;
            size_limit_reg <= 16'hFFFF;
            closed_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_CAPACITY:   capacity_reg   <= cfg_data[4:0];
                CFG_SIZE_LIMIT: size_limit_reg <= cfg_data;
                CFG_CLOSED:     closed_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Capacity above the depth behaves as the depth.
    assign cap_int = (32'(capacity_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity_reg);

    rfmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    rfmq_dp #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .capacity     (cap_int),
        .size_limit   (size_limit_reg),
        .queue_closed (closed_reg),
        .kind         (kind),
        .sender       (sender),
        .receiver     (receiver),
        .msg_kind     (msg_kind),
        .msg_size     (msg_size),
        .payload      (payload),
        .room         (room),
        .done         (done),
        .status       (status),
        .out_kind     (out_kind),
        .out_sender   (out_sender),
        .out_id       (out_id),
        .bytes_copied (bytes_copied),
        .out_payload  (out_payload),
        .held         (held)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("done without a preceding busy cycle");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy) else $error("busy held longer than one cycle");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held <= CNT_W'(DEPTH)) else $error("stored count above depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (bytes_copied == 16'd0 && out_id == 32'd0))
        else $error("failed request delivered data");

endmodule

// ===== rtl/core/rfmq_ctrl.sv =====
// Controller state machine for the mailbox queue.
// Depends on rfmq_pkg.
module rfmq_ctrl
    import rfmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output rfmq_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg == S_EXEC);
    assign cmd.load   = start && (state_reg == S_IDLE);
    assign cmd.finish = (state_reg == S_EXEC);

endmodule

// ===== rtl/core/rfmq_dp.sv =====
// Datapath: shift-register slot array, receiver match, collapse, result register.
// Depends on rfmq_pkg.
module rfmq_dp
    import rfmq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CNT_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rfmq_cmd_t        cmd,
    input  logic [CNT_W-1:0] capacity,
    input  logic [15:0]      size_limit,
    input  logic             queue_closed,
    input  logic [1:0]       kind,
    input  logic [31:0]      sender,
    input  logic [31:0]      receiver,
    input  logic [7:0]       msg_kind,
    input  logic [15:0]      msg_size,
    input  logic [63:0]      payload,
    input  logic [15:0]      room,
    output logic             done,
    output logic [2:0]       status,
    output logic [7:0]       out_kind,
    output logic [31:0]      out_sender,
    output logic [31:0]      out_id,
    output logic [15:0]      bytes_copied,
    output logic [63:0]      out_payload,
    output logic [CNT_W-1:0] held
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] s_sender  [DEPTH];
    logic [31:0] s_recv    [DEPTH];
    logic [7:0]  s_kind    [DEPTH];
    logic [15:0] s_size    [DEPTH];
    logic [63:0] s_payload [DEPTH];
    logic [31:0] s_id      [DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      next_id_reg;
    logic             done_reg;

    // Latched request.
    op_t         op_reg;
    logic [31:0] snd_reg, rcv_reg;
    logic [7:0]  mk_reg;
    logic [15:0] msz_reg, room_reg;
    logic [63:0] pay_reg;

    // Match vector registered in the load cycle.
    logic [DEPTH-1:0] hit_reg, hit_next;

    logic [2:0]  status_reg;
    logic [7:0]  okind_reg;
    logic [31:0] osnd_reg, oid_reg;
    logic [15:0] bytes_reg;
    logic [63:0] opay_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_next[i] = (CNT_W'(i) < count_reg) &&
                ((receiver == 32'd0) || (s_recv[i] == 32'd0) || (s_recv[i] == receiver));
        end
    end

    // Oldest match: lowest index set.
    logic [DEPTH-1:0] first_oh;
    logic [IDX_W-1:0] first_idx;
    logic             any_hit;

    always_comb
    begin
        first_oh  = hit_reg & (~hit_reg + DEPTH'(1));
        any_hit   = |hit_reg;
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_oh[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end

    logic             full;
    logic [IDX_W-1:0] wr_idx;

    assign full   = (count_reg >= capacity) || (count_reg >= CNT_W'(DEPTH));
    assign wr_idx = count_reg[IDX_W-1:0];

    logic        do_push, do_pop;
    logic [2:0]  st;
    logic [15:0] sz;

    always_comb
    begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        st         = ST_OK;
        count_next = count_reg;
        sz         = s_size[first_idx];
        priority if (op_reg == OP_FLUSH)
        begin
            count_next = '0;
        end
        else if (op_reg == OP_SEND)
        begin
            priority if (queue_closed)           st = ST_CLOSED;
            else if (msz_reg > size_limit)       st = ST_TOO_LARGE;
            else if (full)                       st = ST_FULL;
            else
            begin
                do_push    = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            priority if (queue_closed)           st = ST_CLOSED;
            else if (room_reg == 16'd0)          st = ST_BAD_BUFFER;
            else if (!any_hit)                   st = ST_NO_MATCH;
            else if (op_reg == OP_RECEIVE)
            begin
                do_pop     = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(kind);
            snd_reg  <= sender;
            rcv_reg  <= receiver;
            mk_reg   <= msg_kind;
            msz_reg  <= msg_size;
            pay_reg  <= payload;
            room_reg <= room;
            hit_reg  <= hit_next;
        end
        if (cmd.finish)
        begin
            status_reg <= st;
            okind_reg  <= 8'd0;
            osnd_reg   <= 32'd0;
            oid_reg    <= 32'd0;
            bytes_reg  <= 16'd0;
            opay_reg   <= 64'd0;
            if (do_push)
            begin
                oid_reg <= next_id_reg;
            end
            if ((op_reg == OP_RECEIVE || op_reg == OP_PEEK) && st == ST_OK)
            begin
                okind_reg <= s_kind[first_idx];
                osnd_reg  <= s_sender[first_idx];
                oid_reg   <= s_id[first_idx];
                opay_reg  <= s_payload[first_idx];
                bytes_reg <= (sz < room_reg) ? sz : room_reg;
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_push && wr_idx == IDX_W'(i))
                begin
                    s_sender[i]  <= snd_reg;
                    s_recv[i]    <= rcv_reg;
                    s_kind[i]    <= mk_reg;
                    s_size[i]    <= msz_reg;
                    s_payload[i] <= pay_reg;
                    s_id[i]      <= next_id_reg;
                end
                else if (do_pop && IDX_W'(i) >= first_idx && i + 1 < DEPTH)
                begin
                    s_sender[i]  <= s_sender[(i + 1) % DEPTH];
                    s_recv[i]    <= s_recv[(i + 1) % DEPTH];
                    s_kind[i]    <= s_kind[(i + 1) % DEPTH];
                    s_size[i]    <= s_size[(i + 1) % DEPTH];
                    s_payload[i] <= s_payload[(i + 1) % DEPTH];
                    s_id[i]      <= s_id[(i + 1) % DEPTH];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= 32'd1;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                count_reg <= count_next;
                if (do_push)
                begin
                    next_id_reg <= next_id_reg + 32'd1;
                end
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_kind     = okind_reg;
    assign out_sender   = osnd_reg;
    assign out_id       = oid_reg;
    assign bytes_copied = bytes_reg;
    assign out_payload  = opay_reg;
    assign held         = count_reg;

endmodule

// ===== tb/sv/receiver_filtered_mailbox_queue_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the receiver-filtered mailbox queue: directed and random
// requests, a mailbox predictor and a per-field compare of every done beat.
// Depends on rfmq_pkg and receiver_filtered_mailbox_queue_top.
module receiver_filtered_mailbox_queue_top_tb
    import rfmq_pkg::*;
();

    localparam int DEPTH = 16;

    typedef struct {
        op_t         op;
        logic [31:0] snd;
        logic [31:0] rcv;
        logic [7:0]  mk;
        logic [15:0] msz;
        logic [63:0] pay;
        logic [15:0] rm;
        logic        cfg;
        cfg_idx_t    cidx;
        logic [15:0] cval;
        logic        drain;
        int          mode;
    } request_t;

    typedef struct {
        status_t     st;
        logic [7:0]  okind;
        logic [31:0] osnd;
        logic [31:0] oid;
        logic [15:0] bytes;
        logic [63:0] opay;
        logic [4:0]  held;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] sender;
    logic [31:0] receiver;
    logic [7:0]  msg_kind;
    logic [15:0] msg_size;
    logic [63:0] payload;
    logic [15:0] room;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  out_kind;
    logic [31:0] out_sender;
    logic [31:0] out_id;
    logic [15:0] bytes_copied;
    logic [63:0] out_payload;
    logic [4:0]  held;

    request_t pending_q[$];
    reply_t   reply_q[$];
    request_t cur_req;
    int       failures;

    logic [31:0] m_snd[DEPTH];
    logic [31:0] m_rcv[DEPTH];
    logic [7:0]  m_kind[DEPTH];
    logic [15:0] m_size[DEPTH];
    logic [63:0] m_pay[DEPTH];
    logic [31:0] m_id[DEPTH];
    int          m_count;
    logic [31:0] m_next_id;
    logic [4:0]  m_capacity;
    logic [15:0] m_limit;
    logic        m_closed;

    receiver_filtered_mailbox_queue_top #(.DEPTH(DEPTH)) u_top (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic reply_t mailbox_step(request_t r);
        reply_t o;
        int     hit;
        o = '{ST_OK, 8'd0, 32'd0, 32'd0, 16'd0, 64'd0, 5'd0};
        hit = -1;
        if (r.op == OP_SEND)
        begin
            if (m_closed) o.st = ST_CLOSED;
            else if (r.msz > m_limit) o.st = ST_TOO_LARGE;
            else if (m_count >= m_capacity || m_count >= DEPTH) o.st = ST_FULL;
            else
            begin
                m_snd[m_count] = r.snd;
                m_rcv[m_count] = r.rcv;
                m_kind[m_count] = r.mk;
                m_size[m_count] = r.msz;
                m_pay[m_count] = r.pay;
                m_id[m_count] = m_next_id;
                o.oid = m_next_id;
                m_next_id = m_next_id + 32'd1;
                m_count++;
            end
        end
        else if (r.op == OP_FLUSH)
        begin
            m_count = 0;
        end
        else
        begin
            if (m_closed) o.st = ST_CLOSED;
            else if (r.rm == 16'd0) o.st = ST_BAD_BUFFER;
            else
            begin
                for (int i = 0; i < m_count; i++)
                    if (hit < 0 && (r.rcv == 0 || m_rcv[i] == 0 || m_rcv[i] == r.rcv))
                        hit = i;
                if (hit < 0) o.st = ST_NO_MATCH;
                else
                begin
                    o.okind = m_kind[hit];
                    o.osnd = m_snd[hit];
                    o.oid = m_id[hit];
                    o.opay = m_pay[hit];
                    o.bytes = m_size[hit] < r.rm ? m_size[hit] : r.rm;
                    if (r.op == OP_RECEIVE)
                    begin
                        for (int i = hit; i + 1 < m_count; i++)
                        begin
                            m_snd[i] = m_snd[i + 1];
                            m_rcv[i] = m_rcv[i + 1];
                            m_kind[i] = m_kind[i + 1];
                            m_size[i] = m_size[i + 1];
                            m_pay[i] = m_pay[i + 1];
                            m_id[i] = m_id[i + 1];
                        end
                        m_count--;
                    end
                end
            end
        end
        o.held = 5'(m_count);
        return o;
    endfunction

    function automatic request_t make_op(op_t op, logic [31:0] rcv, logic [15:0] msz,
                                         logic [15:0] rm, int mode);
        request_t r;
        r.op = op;
        r.snd = $urandom >> $urandom_range(0, 31);
        r.rcv = rcv;
        r.mk = 8'($urandom);
        r.msz = msz;
        r.pay = {$urandom, $urandom};
        r.rm = rm;
        r.cfg = 1'b0;
        r.cidx = CFG_CAPACITY;
        r.cval = '0;
        r.drain = 1'b0;
        r.mode = mode;
        return r;
    endfunction

    function automatic request_t make_cfg(cfg_idx_t idx, logic [15:0] val, int mode);
        request_t r;
        r = make_op(OP_FLUSH, 32'd0, 16'd0, 16'd0, mode);
        r.cfg = 1'b1;
        r.cidx = idx;
        r.cval = val;
        return r;
    endfunction

    function automatic request_t random_op(int mode);
        op_t         op;
        logic [31:0] rcv;
        logic [15:0] sz;
        logic [15:0] rm;
        int          p;
        p = $urandom_range(0, 99);
        op = p < 45 ? OP_SEND : p < 80 ? OP_RECEIVE : p < 96 ? OP_PEEK : OP_FLUSH;
        case ($urandom_range(0, 5))
            0: rcv = 32'd0;
            1: rcv = $urandom;
            default: rcv = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 3))
            0: sz = 16'($urandom);
            1: sz = 16'hFFFF;
            default: sz = 16'($urandom_range(0, 300));
        endcase
        if ($urandom_range(0, 19) == 0)
            rm = 16'd0;
        else if ($urandom_range(0, 1) == 1)
            rm = 16'($urandom);
        else
            rm = 16'($urandom_range(1, 300));
        return make_op(op, rcv, sz, rm, mode);
    endfunction

    // A config entry or a drain mark waits until every expected beat has come back.
    always @(posedge clk)
    begin
        request_t nxt;
        logic     accepted;
        logic     idle_now;
        accepted = start && !busy;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            cfg_idx <= '0;
            cfg_data <= '0;
            kind <= '0;
            sender <= '0;
            receiver <= '0;
            msg_kind <= '0;
            msg_size <= '0;
            payload <= '0;
            room <= '0;
        end
        else
        begin
            cfg_we <= 1'b0;
            if (accepted)
                reply_q.push_back(mailbox_step(cur_req));
            if (!start || accepted)
            begin
                start <= 1'b0;
                if (pending_q.size() > 0)
                begin
                    nxt = pending_q[0];
                    idle_now = (nxt.mode == 1 && $urandom_range(0, 99) < 34) ||
                               (nxt.mode == 2 && $urandom_range(0, 99) < 78);
                    if (nxt.cfg)
                    begin
                        if (reply_q.size() == 0)
                        begin
                            void'(pending_q.pop_front());
                            cfg_we <= 1'b1;
                            cfg_idx <= nxt.cidx;
                            cfg_data <= nxt.cval;
                            case (nxt.cidx)
                                CFG_CAPACITY: m_capacity = nxt.cval[4:0];
                                CFG_SIZE_LIMIT: m_limit = nxt.cval;
                                CFG_CLOSED: m_closed = nxt.cval[0];
                                default: ;
                            endcase
                        end
                    end
                    else if (!(nxt.drain && reply_q.size() > 0) && !idle_now)
                    begin
                        void'(pending_q.pop_front());
                        cur_req = nxt;
                        start <= 1'b1;
                        kind <= nxt.op;
                        sender <= nxt.snd;
                        receiver <= nxt.rcv;
                        msg_kind <= nxt.mk;
                        msg_size <= nxt.msz;
                        payload <= nxt.pay;
                        room <= nxt.rm;
                    end
                end
            end
        end
    end

    // Monitor: compares each done beat with the oldest prediction.
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                $error("unexpected result beat");
                failures++;
            end
            else
            begin
                e = reply_q.pop_front();
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status); failures++;
                end
                if (out_kind !== e.okind)
                begin
                    $error("out_kind exp %0h got %0h", e.okind, out_kind); failures++;
                end
                if (out_sender !== e.osnd)
                begin
                    $error("out_sender exp %0h got %0h", e.osnd, out_sender); failures++;
                end
                if (out_id !== e.oid)
                begin
                    $error("out_id exp %0h got %0h", e.oid, out_id); failures++;
                end
                if (bytes_copied !== e.bytes)
                begin
                    $error("bytes_copied exp %0h got %0h", e.bytes, bytes_copied);
                    failures++;
                end
                if (out_payload !== e.opay)
                begin
                    $error("out_payload exp %0h got %0h", e.opay, out_payload); failures++;
                end
                if (held !== e.held)
                begin
                    $error("held exp %0d got %0d", e.held, held); failures++;
                end
            end
        end
    end

    initial
    begin
        request_t r;
        rst_n = 1'b0;
        failures = 0;
        m_count = 0;
        m_next_id = 32'd1;
        m_capacity = 5'd16;
        m_limit = 16'hFFFF;
        m_closed = 1'b0;

        for (int i = 0; i < 17; i++)
            pending_q.push_back(make_op(OP_SEND, 32'(i % 3), 16'(i * 7), 16'd5, 0));
        pending_q.push_back(make_op(OP_PEEK, 32'd2, 16'd0, 16'd0, 0));
        pending_q.push_back(make_op(OP_PEEK, 32'd2, 16'd0, 16'hFFFF, 0));
        pending_q.push_back(make_op(OP_RECEIVE, 32'd1, 16'd0, 16'd1, 0));
        pending_q.push_back(make_op(OP_RECEIVE, 32'hFFFF_FFFF, 16'd0, 16'd3, 0));
        pending_q.push_back(make_op(OP_RECEIVE, 32'd0, 16'd0, 16'hFFFF, 0));
        pending_q.push_back(make_op(OP_FLUSH, 32'd0, 16'd0, 16'd0, 0));
        pending_q.push_back(make_op(OP_RECEIVE, 32'd0, 16'd0, 16'd9, 0));
        pending_q.push_back(make_cfg(CFG_SIZE_LIMIT, 16'd1, 0));
        pending_q.push_back(make_op(OP_SEND, 32'hFFFF_FFFF, 16'd2, 16'd0, 0));
        pending_q.push_back(make_op(OP_SEND, 32'hFFFF_FFFF, 16'd1, 16'd0, 0));
        pending_q.push_back(make_cfg(CFG_CLOSED, 16'd1, 0));
        pending_q.push_back(make_op(OP_SEND, 32'd0, 16'd0, 16'd1, 0));
        pending_q.push_back(make_op(OP_RECEIVE, 32'd0, 16'd0, 16'd0, 0));
        pending_q.push_back(make_op(OP_PEEK, 32'd0, 16'd0, 16'd1, 0));
        pending_q.push_back(make_op(OP_FLUSH, 32'd0, 16'd0, 16'd0, 0));
        pending_q.push_back(make_cfg(CFG_CLOSED, 16'd0, 0));
        pending_q.push_back(make_cfg(CFG_CAPACITY, 16'd0, 0));
        pending_q.push_back(make_op(OP_SEND, 32'd0, 16'd0, 16'd1, 0));
        pending_q.push_back(make_cfg(CFG_SIZE_LIMIT, 16'hFFFF, 0));

        for (int ph = 0; ph < 9; ph++)
        begin
            int mode;
            mode = ph < 3 ? 1 : ph < 6 ? 2 : 3;
            pending_q.push_back(make_cfg(CFG_CAPACITY,
                ph % 3 == 0 ? 16'd1 : ph % 3 == 1 ? 16'd16 : 16'($urandom_range(2, 15)), mode));
            pending_q.push_back(make_cfg(CFG_SIZE_LIMIT,
                ph % 4 == 3 ? 16'($urandom_range(1, 400)) : 16'hFFFF, mode));
            pending_q.push_back(make_cfg(CFG_CLOSED, 16'(ph == 4), mode));
            for (int k = 0; k < 110; k++)
            begin
                r = random_op(mode);
                r.drain = (k == 55);
                pending_q.push_back(r);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_q.size() > 0 || reply_q.size() > 0 || start);
        repeat (10) @(posedge clk);
        if (reply_q.size() > 0)
        begin
            $error("%0d results never arrived", reply_q.size());
            failures++;
        end
        if (failures == 0)
            $display("receiver_filtered_mailbox_queue_top: match");
        else
            $display("receiver_filtered_mailbox_queue_top: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("receiver_filtered_mailbox_queue_top: mismatch");
        $finish;
    end

endmodule
